### rtl/tts_pkg.sv
// Shared types, codes and defaults of the tick task scheduler.
`default_nettype none

package tts_pkg;

	localparam int MAX_TASKS_DEF = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [2:0] ACT_CLEAR    = 3'd0;
	localparam logic [2:0] ACT_ADD      = 3'd1;
	localparam logic [2:0] ACT_TICK     = 3'd2;
	localparam logic [2:0] ACT_DISPATCH = 3'd3;
	localparam logic [2:0] ACT_DELETE   = 3'd4;

	localparam logic [2:0] OP_CLEAR    = 3'd0;
	localparam logic [2:0] OP_ADD      = 3'd1;
	localparam logic [2:0] OP_TICK     = 3'd2;
	localparam logic [2:0] OP_DISPATCH = 3'd3;
	localparam logic [2:0] OP_DELETE   = 3'd4;
	localparam logic [2:0] OP_NOP      = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_BAD_INDEX = 2'd2;

	localparam logic KIND_ACK = 1'b0;
	localparam logic KIND_RUN = 1'b1;

	localparam logic [7:0] PENDING_MAX = 8'hFF;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  task_handle;
		logic [31:0] start_delay;
		logic [31:0] repeat_period;
		logic [3:0]  slot_index;
	} cmd_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] run_handle;
		logic [1:0] status;
		logic       last_of_run;
	} result_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  task_handle;
		logic [31:0] start_delay;
		logic [31:0] repeat_period;
		logic [3:0]  slot_index;
	} q_item_t;

	typedef struct packed {
		logic valid;
		logic pop;
	} q_ctrl_t;

	typedef struct packed {
		logic [7:0]  handle;
		logic [31:0] countdown;
		logic [31:0] period;
		logic [7:0]  pending;
	} entry_t;

endpackage

`default_nettype wire

### rtl/tts_front.sv
// Front end: accepts command words, classifies the action and queues them.
`default_nettype none

module tts_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire tts_pkg::cmd_t    cmd,
	output logic                  busy,
	input  wire logic             q_pop,
	output logic                  q_valid,
	output tts_pkg::q_item_t      q_item
);
	import tts_pkg::*;

	q_item_t    slots_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       push;
	logic       pop;
	logic [2:0] op_c;

	always_comb begin
		unique case (cmd.action)
			ACT_CLEAR:    op_c = OP_CLEAR;
			ACT_ADD:      op_c = OP_ADD;
			ACT_TICK:     op_c = OP_TICK;
			ACT_DISPATCH: op_c = OP_DISPATCH;
			ACT_DELETE:   op_c = OP_DELETE;
			default:      op_c = OP_NOP;
		endcase
	end

	assign busy    = (fill_q == 2'(QUEUE_DEPTH));
	assign push    = start && !busy;
	assign q_valid = (fill_q != 2'd0);
	assign pop     = q_pop && q_valid;
	assign q_item  = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= '{op: op_c, task_handle: cmd.task_handle,
				start_delay: cmd.start_delay, repeat_period: cmd.repeat_period,
				slot_index: cmd.slot_index};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) fill_q <= fill_q + 2'd1;
			else if (pop && !push) fill_q <= fill_q - 2'd1;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 2'(QUEUE_DEPTH))
		else $error("queue fill count out of range");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from an empty queue");

	a_busy_full: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && !q_pop) |=> busy)
		else $error("queue lost a word without a pop");

endmodule

`default_nettype wire

### rtl/tts_back.sv
// Back end: owns the task table memory and walks it to execute queued commands.
`default_nettype none

module tts_back #(
	parameter int MAX_TASKS = tts_pkg::MAX_TASKS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire tts_pkg::q_item_t q_item,
	output logic                  q_pop,
	output logic                  strobe,
	output tts_pkg::result_t      result
);
	import tts_pkg::*;

	localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	entry_t         mem [MAX_TASKS];
	logic           state_q;
	logic [2:0]     op_q;
	logic [CW-1:0]  count_q;
	logic [CW-1:0]  ptr_q;
	logic           vld_s1;
	logic [AW-1:0]  addr_s1;
	entry_t         rdata_s1;
	logic           held_vld_q;
	logic [7:0]     held_handle_q;
	logic           strobe_q;
	result_t        res_q;

	logic           we_c;
	logic [AW-1:0]  waddr_c;
	entry_t         wdata_c;
	logic           issue_c;
	logic           emit_c;
	result_t        res_c;
	q_ctrl_t        qc;

	assign qc.valid = q_valid;
	assign qc.pop   = (state_q == ST_IDLE) && qc.valid;
	assign q_pop    = qc.pop;
	assign issue_c  = (state_q == ST_WALK) && (ptr_q < count_q);
	assign strobe   = strobe_q;
	assign result   = res_q;

	always_comb begin
		we_c    = 1'b0;
		waddr_c = count_q[AW-1:0];
		wdata_c = '{handle: q_item.task_handle, countdown: q_item.start_delay,
			period: q_item.repeat_period, pending: 8'd0};
		emit_c  = 1'b0;
		res_c   = '{kind: KIND_ACK, run_handle: 8'd0, status: ST_OK, last_of_run: 1'b1};
		if (qc.pop) begin
			unique case (q_item.op)
				OP_ADD: begin
					emit_c = 1'b1;
					if (count_q == CW'(MAX_TASKS)) res_c.status = ST_FULL;
					else we_c = 1'b1;
				end
				OP_DELETE: begin
					if (8'(q_item.slot_index) >= 8'(count_q)) begin
						emit_c       = 1'b1;
						res_c.status = ST_BAD_INDEX;
					end
				end
				OP_TICK, OP_DISPATCH: ;
				default: emit_c = 1'b1;
			endcase
		end else if (state_q == ST_WALK) begin
			if (vld_s1) begin
				waddr_c = addr_s1;
				wdata_c = rdata_s1;
				unique case (op_q)
					OP_TICK: begin
						we_c = 1'b1;
						if (rdata_s1.countdown != 32'd0) begin
							wdata_c.countdown = rdata_s1.countdown - 32'd1;
						end else begin
							wdata_c.countdown = rdata_s1.period;
							if (rdata_s1.pending != PENDING_MAX) begin
								wdata_c.pending = rdata_s1.pending + 8'd1;
							end
						end
					end
					OP_DISPATCH: begin
						if (rdata_s1.pending != 8'd0) begin
							we_c            = 1'b1;
							wdata_c.pending = rdata_s1.pending - 8'd1;
							if (held_vld_q) begin
								emit_c = 1'b1;
								res_c  = '{kind: KIND_RUN, run_handle: held_handle_q,
									status: ST_OK, last_of_run: 1'b0};
							end
						end
					end
					default: begin
						we_c    = 1'b1;
						waddr_c = addr_s1 - AW'(1);
					end
				endcase
			end else if (!issue_c) begin
				emit_c = 1'b1;
				if (op_q == OP_DISPATCH && held_vld_q) begin
					res_c = '{kind: KIND_RUN, run_handle: held_handle_q,
						status: ST_OK, last_of_run: 1'b1};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we_c) mem[waddr_c] <= wdata_c;
		rdata_s1 <= mem[ptr_q[AW-1:0]];
		addr_s1  <= ptr_q[AW-1:0];
		res_q    <= res_c;
		if (state_q == ST_WALK && vld_s1 && op_q == OP_DISPATCH
			&& rdata_s1.pending != 8'd0) begin
			held_handle_q <= rdata_s1.handle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			op_q       <= OP_NOP;
			count_q    <= '0;
			ptr_q      <= '0;
			vld_s1     <= 1'b0;
			held_vld_q <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			strobe_q <= emit_c;
			vld_s1   <= issue_c;
			if (issue_c) ptr_q <= ptr_q + CW'(1);
			if (qc.pop) begin
				op_q       <= q_item.op;
				held_vld_q <= 1'b0;
				unique case (q_item.op)
					OP_CLEAR: count_q <= '0;
					OP_ADD: begin
						if (count_q != CW'(MAX_TASKS)) count_q <= count_q + CW'(1);
					end
					OP_TICK, OP_DISPATCH: begin
						ptr_q   <= '0;
						state_q <= ST_WALK;
					end
					OP_DELETE: begin
						if (8'(q_item.slot_index) < 8'(count_q)) begin
							ptr_q   <= CW'(q_item.slot_index) + CW'(1);
							state_q <= ST_WALK;
						end
					end
					default: ;
				endcase
			end else if (state_q == ST_WALK) begin
				if (vld_s1 && op_q == OP_DISPATCH && rdata_s1.pending != 8'd0) begin
					held_vld_q <= 1'b1;
				end
				if (!vld_s1 && !issue_c) begin
					state_q <= ST_IDLE;
					if (op_q == OP_DELETE) count_q <= count_q - CW'(1);
				end
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_TASKS))
		else $error("task count beyond table size");

	a_ack_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && res_q.kind == KIND_ACK) |-> res_q.last_of_run)
		else $error("acknowledge not marked as final word");

	a_run_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && res_q.kind == KIND_RUN) |-> (res_q.status == ST_OK))
		else $error("run word carries an error status");

	a_stage_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == ST_WALK))
		else $error("table read in flight outside a walk");

endmodule

`default_nettype wire

### rtl/tick_task_scheduler.sv
// Top level of the tick task scheduler: command queue front end and table back end.
//
// Channel   Direction  Handshake                 Payload
// command   in         start high, busy low      cmd    (tts_pkg::cmd_t)
// result    out        strobe high, one cycle    result (tts_pkg::result_t)
//
// Clear, add, an unknown action and a rejected delete are handled as they are dequeued.
// Tick and dispatch dequeue, then walk the table, reading each entry through the read
// port and writing its update back through the write port.
// Delete at index i dequeues, then shifts the entries after i down by one place.
// The two-word command queue lets commands arrive while the back end walks; busy means full.
// Reset is asynchronous and empties the table; the receiver cannot stall results.
`default_nettype none

module tick_task_scheduler #(
	parameter int MAX_TASKS = tts_pkg::MAX_TASKS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire tts_pkg::cmd_t     cmd,
	output logic                   busy,
	output logic                   strobe,
	output tts_pkg::result_t       result
);
	import tts_pkg::*;

	logic    q_pop;
	logic    q_valid;
	q_item_t q_item;

	tts_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.cmd     (cmd),
		.busy    (busy),
		.q_pop   (q_pop),
		.q_valid (q_valid),
		.q_item  (q_item)
	);

	tts_back #(
		.MAX_TASKS (MAX_TASKS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.strobe  (strobe),
		.result  (result)
	);

endmodule

`default_nettype wire

### bench/tts_scoreboard.sv
// Scoreboard for the tick task scheduler: tracks the task table and checks every result word.
`default_nettype none

module tts_scoreboard
	import tts_pkg::*;
#(
	parameter int MAX_TASKS = MAX_TASKS_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire cmd_t    cmd,
	input  wire logic    busy,
	input  wire logic    strobe,
	input  wire result_t result,
	output int           errors,
	output int           in_flight,
	output int           run_total,
	output int           full_total,
	output int           bad_index_total,
	output int           saturated_total
);

	timeunit 1ns;
	timeprecision 1ps;

	entry_t slots [MAX_TASKS];
	int unsigned task_total;
	result_t awaited_results [$];

	function automatic string describe(input result_t r);
		return $sformatf("kind %0d handle %02h status %0d last %0d",
			r.kind, r.run_handle, r.status, r.last_of_run);
	endfunction

	task automatic schedule_step(input cmd_t c);
		logic [1:0] st;
		int fired;
		result_t r;
		st = ST_OK;
		fired = 0;
		case (c.action)
			ACT_CLEAR: begin
				task_total = 0;
			end
			ACT_ADD: begin
				if (task_total >= MAX_TASKS) begin
					st = ST_FULL;
					full_total++;
				end else begin
					slots[task_total] = '{c.task_handle, c.start_delay, c.repeat_period, 8'd0};
					task_total++;
				end
			end
			ACT_TICK: begin
				for (int i = 0; i < task_total; i++) begin
					if (slots[i].countdown != 0) begin
						slots[i].countdown--;
					end else begin
						slots[i].countdown = slots[i].period;
						if (slots[i].pending != PENDING_MAX)
							slots[i].pending++;
						else
							saturated_total++;
					end
				end
			end
			ACT_DISPATCH: begin
				for (int i = 0; i < task_total; i++) begin
					if (slots[i].pending != 0) begin
						slots[i].pending--;
						awaited_results.push_back('{KIND_RUN, slots[i].handle, ST_OK, 1'b0});
						fired++;
					end
				end
				if (fired > 0) begin
					r = awaited_results.pop_back();
					r.last_of_run = 1'b1;
					awaited_results.push_back(r);
					run_total += fired;
				end
			end
			ACT_DELETE: begin
				if (c.slot_index >= task_total) begin
					st = ST_BAD_INDEX;
					bad_index_total++;
				end else begin
					for (int i = c.slot_index; i + 1 < task_total; i++)
						slots[i] = slots[i + 1];
					task_total--;
				end
			end
			default: begin
			end
		endcase
		if (c.action != ACT_DISPATCH || fired == 0)
			awaited_results.push_back('{KIND_ACK, 8'd0, st, 1'b1});
	endtask

	always @(posedge clk) begin
		result_t due;
		if (!arst_n) begin
			task_total = 0;
			awaited_results.delete();
		end else begin
			if (strobe !== 1'b0) begin
				if (awaited_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word: %s", $time, describe(result));
				end else begin
					due = awaited_results.pop_front();
					if (result.kind !== due.kind || result.run_handle !== due.run_handle ||
							result.status !== due.status ||
							result.last_of_run !== due.last_of_run) begin
						errors++;
						$display("%0t: result mismatch: expected %s, got %s",
							$time, describe(due), describe(result));
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				schedule_step(cmd);
		end
		in_flight = awaited_results.size();
	end

endmodule

`default_nettype wire

### bench/tb_tick_task_scheduler.sv
// Testbench top for the tick task scheduler: clock, reset, command stimulus and verdict.
`default_nettype none

module tb_tick_task_scheduler;

	timeunit 1ns;
	timeprecision 1ps;

	import tts_pkg::*;

	localparam logic [2:0] ACT_HIGHEST = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy;
	logic strobe;
	result_t result;

	int fail_total;
	int in_flight;
	int runs;
	int fulls;
	int bad_indexes;
	int saturations;
	int sent;

	always #6 clk = ~clk;

	tick_task_scheduler dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	tts_scoreboard u_score (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.cmd             (cmd),
		.busy            (busy),
		.strobe          (strobe),
		.result          (result),
		.errors          (fail_total),
		.in_flight       (in_flight),
		.run_total       (runs),
		.full_total      (fulls),
		.bad_index_total (bad_indexes),
		.saturated_total (saturations)
	);

	function automatic cmd_t word(input logic [2:0] act, input logic [7:0] h,
			input logic [31:0] delay, input logic [31:0] period, input logic [3:0] slot);
		return '{act, h, delay, period, slot};
	endfunction

	function automatic logic [2:0] pick_action(input int r, input int c0, input int c1,
			input int c2, input int c3, input int c4);
		if (r < c0) return ACT_CLEAR;
		if (r < c1) return ACT_ADD;
		if (r < c2) return ACT_TICK;
		if (r < c3) return ACT_DISPATCH;
		if (r < c4) return ACT_DELETE;
		return 3'($urandom_range(OP_NOP, ACT_HIGHEST));
	endfunction

	function automatic cmd_t random_word(input int mode);
		cmd_t w;
		int r;
		w.task_handle = 8'($urandom);
		w.start_delay = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4);
		w.repeat_period = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4);
		w.slot_index = ($urandom_range(0, 2) == 0) ? 4'($urandom) : 4'($urandom_range(0, 7));
		r = $urandom_range(0, 99);
		case (mode)
			0: w.action = pick_action(r, 3, 28, 58, 83, 95);
			1: w.action = pick_action(r, 1, 61, 76, 91, 97);
			2: w.action = pick_action(r, 1, 16, 61, 91, 97);
			default: w.action = pick_action(r, 5, 35, 55, 70, 90);
		endcase
		return w;
	endfunction

	function automatic int draw_gap(input bit burst);
		return burst ? 0 : $urandom_range(0, 18);
	endfunction

	task automatic send_word(input cmd_t w, input int gap);
		cmd <= w;
		start <= 1'b1;
		@(negedge clk);
		while (busy !== 1'b0)
			@(negedge clk);
		@(posedge clk);
		sent++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		do
			@(negedge clk);
		while (in_flight != 0);
		@(posedge clk);
	endtask

	initial begin
		#3_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		bit burst;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table first, then a small table with extreme fields.
		send_word(word(ACT_CLEAR, 8'h00, 32'h0, 32'h0, 4'h0), draw_gap(0));
		send_word(word(ACT_DISPATCH, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF), draw_gap(0));
		send_word(word(ACT_TICK, 8'h00, 32'h0, 32'h0, 4'h0), draw_gap(0));
		send_word(word(ACT_DELETE, 8'h00, 32'h0, 32'h0, 4'h0), draw_gap(0));
		send_word(word(ACT_ADD, 8'h00, 32'h0, 32'h0, 4'h0), draw_gap(0));
		send_word(word(ACT_ADD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF), draw_gap(0));
		send_word(word(ACT_ADD, 8'h5A, 32'h1, 32'h2, 4'h0), draw_gap(0));
		send_word(word(ACT_ADD, 8'hA5, 32'h0, 32'hFFFF_FFFF, 4'h0), draw_gap(0));
		send_word(word(ACT_TICK, 8'h00, 32'h0, 32'h0, 4'h0), draw_gap(0));
		send_word(word(ACT_TICK, 8'h00, 32'h0, 32'h0, 4'h0), draw_gap(0));
		send_word(word(ACT_DISPATCH, 8'h00, 32'h0, 32'h0, 4'h0), draw_gap(0));
		send_word(word(ACT_DISPATCH, 8'h00, 32'h0, 32'h0, 4'h0), draw_gap(0));
		send_word(word(ACT_DISPATCH, 8'h00, 32'h0, 32'h0, 4'h0), draw_gap(0));
		send_word(word(ACT_DELETE, 8'h00, 32'h0, 32'h0, 4'hF), draw_gap(0));
		send_word(word(ACT_DELETE, 8'h00, 32'h0, 32'h0, 4'h4), draw_gap(0));
		send_word(word(ACT_DELETE, 8'h00, 32'h0, 32'h0, 4'h3), draw_gap(0));
		send_word(word(ACT_DELETE, 8'h00, 32'h0, 32'h0, 4'h0), draw_gap(0));
		send_word(word(OP_NOP, 8'h00, 32'h0, 32'h0, 4'h0), draw_gap(0));
		send_word(word(3'd6, 8'h00, 32'h0, 32'h0, 4'h0), draw_gap(0));
		send_word(word(ACT_HIGHEST, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF), draw_gap(0));
		send_word(word(ACT_TICK, 8'h00, 32'h0, 32'h0, 4'h0), draw_gap(0));
		send_word(word(ACT_DISPATCH, 8'h00, 32'h0, 32'h0, 4'h0), draw_gap(0));
		send_word(word(ACT_CLEAR, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF), draw_gap(0));
		send_word(word(ACT_DISPATCH, 8'h00, 32'h0, 32'h0, 4'h0), draw_gap(0));

		for (int ph = 0; ph < 8; ph++) begin
			burst = (ph == 2) || ($urandom_range(0, 2) == 0);
			if (ph == 4)
				drain();
			for (int k = 0; k < 14; k++)
				send_word(random_word(ph % 4), draw_gap(burst));
		end

		// Two zero-period tasks ticked long enough to pin their pending counts.
		send_word(word(ACT_CLEAR, 8'h00, 32'h0, 32'h0, 4'h0), 0);
		send_word(word(ACT_ADD, 8'($urandom), 32'h0, 32'h0, 4'h0), 0);
		send_word(word(ACT_ADD, 8'($urandom), 32'h0, 32'h0, 4'h0), 0);
		repeat (260)
			send_word(word(ACT_TICK, 8'($urandom), $urandom, $urandom, 4'($urandom)), 0);
		repeat (2)
			send_word(word(ACT_DISPATCH, 8'h00, 32'h0, 32'h0, 4'h0), draw_gap(0));

		drain();
		repeat (40) @(posedge clk);
		$display("Sent %0d command words: %0d task runs, %0d adds to a full table, %0d bad deletes.",
			sent, runs, fulls, bad_indexes);
		$display("Pending counts held at their ceiling on %0d reloads.", saturations);
		if (fail_total == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

`default_nettype wire

### tick_task_scheduler.f
rtl/tts_pkg.sv
rtl/tts_front.sv
rtl/tts_back.sv
rtl/tick_task_scheduler.sv
bench/tts_scoreboard.sv
bench/tb_tick_task_scheduler.sv
